>>> rtl/core/adc_ssc_pkg.sv
// ----------------------------------------------------------------------------
// adc_ssc_pkg
// Shared types and constants of the A/D single/scan controller: request
// codes, register offsets, ADCSR/ADCR bit positions and conversion lengths.
// ----------------------------------------------------------------------------
package adc_ssc_pkg;

  // request codes carried by one transfer
  typedef enum logic [2:0] {
    REQ_READ      = 3'd0,
    REQ_WRITE     = 3'd1,
    REQ_TICK      = 3'd2,
    REQ_TRIGGER   = 3'd3,
    REQ_DTC_CLEAR = 3'd4
  } req_e;

  // register offsets
  localparam logic [3:0] OFF_ADCSR = 4'd8;
  localparam logic [3:0] OFF_ADCR  = 4'd9;

  // ADCSR bit positions
  localparam int unsigned ADF_POS  = 7;
  localparam int unsigned ADIE_POS = 6;
  localparam int unsigned ADST_POS = 5;
  localparam int unsigned SCAN_POS = 4;
  localparam int unsigned CKS_POS  = 3;

  // ADCR bit positions and fixed bits
  localparam int unsigned TRGE_POS   = 7;
  localparam logic [6:0]  ADCR_ONES  = 7'h7F;
  localparam logic [7:0]  UNMAPPED_RD = 8'hFF;

  // conversion lengths in states
  localparam int unsigned CNT_W = 9;
  localparam logic [CNT_W-1:0] STATES_FIRST      = 9'd266;
  localparam logic [CNT_W-1:0] STATES_FIRST_FAST = 9'd134;
  localparam logic [CNT_W-1:0] STATES_NEXT       = 9'd256;
  localparam logic [CNT_W-1:0] STATES_NEXT_FAST  = 9'd128;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned NUM_RES  = 4;

  // one input item
  typedef struct packed {
    logic [2:0]          req_type;
    logic [3:0]          offset;
    logic [7:0]          wdata;
    logic [SAMPLE_W-1:0] sample_zero;
    logic [SAMPLE_W-1:0] sample_one;
    logic [SAMPLE_W-1:0] sample_two;
    logic [SAMPLE_W-1:0] sample_three;
  } item_t;

  // one result item
  typedef struct packed {
    logic [7:0] rdata;
    logic       irq_request;
    logic       converting;
  } res_t;

endpackage

>>> rtl/core/adc_ssc_core.sv
// ----------------------------------------------------------------------------
// adc_ssc_core
// Register file, conversion counter and channel sequencer. Applies one
// request per enabled cycle and gives the result of that request.
// ----------------------------------------------------------------------------
module adc_ssc_core
  import adc_ssc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  output res_t  res_o
);

  logic [SAMPLE_W-1:0] result_q [NUM_RES];
  logic [SAMPLE_W-1:0] result_d [NUM_RES];
  logic [7:0]          status_q, status_d;
  logic                trge_q, trge_d;
  logic [7:0]          latch_q, latch_d;
  logic [2:0]          chan_q, chan_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                active_q, active_d;

  // request decode and next state
  always_comb begin
    logic [7:0]          st_new;
    logic [SAMPLE_W-1:0] rd_res;
    logic [SAMPLE_W-1:0] smp;
    logic [2:0]          last_ch;
    logic [2:0]          first_ch;
    logic                do_begin;
    logic [7:0]          begin_st;

    result_d = result_q;
    status_d = status_q;
    trge_d   = trge_q;
    latch_d  = latch_q;
    chan_d   = chan_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    res_o.rdata = 8'h00;
    st_new   = status_q;
    rd_res   = result_q[item_i.offset[2:1]];
    smp      = item_i.sample_zero;
    last_ch  = status_q[2:0];
    first_ch = {status_q[2], 2'b00};
    do_begin = 1'b0;

    case (chan_q[1:0])
      2'd0:    smp = item_i.sample_zero;
      2'd1:    smp = item_i.sample_one;
      2'd2:    smp = item_i.sample_two;
      default: smp = item_i.sample_three;
    endcase

    case (item_i.req_type)
      REQ_READ: begin
        if (!item_i.offset[3]) begin
          if (!item_i.offset[0]) begin
            latch_d     = {rd_res[1:0], 6'b000000};
            res_o.rdata = rd_res[SAMPLE_W-1:2];
          end else begin
            res_o.rdata = latch_q;
          end
        end else if (item_i.offset == OFF_ADCSR) begin
          res_o.rdata = status_q;
        end else if (item_i.offset == OFF_ADCR) begin
          res_o.rdata = {trge_q, ADCR_ONES};
        end else begin
          res_o.rdata = UNMAPPED_RD;
        end
      end
      REQ_WRITE: begin
        if (item_i.offset == OFF_ADCSR) begin
          // a write can clear ADF but never set it
          st_new = {status_q[ADF_POS] & item_i.wdata[ADF_POS], item_i.wdata[6:0]};
          status_d = st_new;
          if (st_new[ADST_POS] && !status_q[ADST_POS]) begin
            do_begin = 1'b1;
          end else if (!st_new[ADST_POS] && status_q[ADST_POS]) begin
            active_d = 1'b0;
            cnt_d    = '0;
          end
        end else if (item_i.offset == OFF_ADCR) begin
          trge_d = item_i.wdata[TRGE_POS];
        end
      end
      REQ_TICK: begin
        if (active_q) begin
          if (cnt_q <= CNT_W'(1)) begin
            // conversion complete: store sample, then stop (single) or advance (scan)
            result_d[chan_q[1:0]] = smp;
            if (!status_q[SCAN_POS]) begin
              status_d[ADF_POS]  = 1'b1;
              status_d[ADST_POS] = 1'b0;
              active_d = 1'b0;
              cnt_d    = '0;
            end else begin
              if (chan_q == last_ch) begin
                status_d[ADF_POS] = 1'b1;
              end
              if (chan_q >= last_ch || chan_q < first_ch) begin
                chan_d = first_ch;
              end else begin
                chan_d = chan_q + 3'd1;
              end
              cnt_d = status_q[CKS_POS] ? STATES_NEXT_FAST : STATES_NEXT;
            end
          end else begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
      end
      REQ_TRIGGER: begin
        if (trge_q && !status_q[ADST_POS]) begin
          st_new = status_q;
          st_new[ADST_POS] = 1'b1;
          status_d = st_new;
          do_begin = 1'b1;
        end
      end
      REQ_DTC_CLEAR: begin
        status_d[ADF_POS] = 1'b0;
      end
      default: begin
      end
    endcase

    // conversion start from the updated ADCSR
    begin_st = st_new;
    if (do_begin) begin
      chan_d   = begin_st[SCAN_POS] ? {begin_st[2], 2'b00} : begin_st[2:0];
      cnt_d    = begin_st[CKS_POS] ? STATES_FIRST_FAST : STATES_FIRST;
      active_d = 1'b1;
    end

    res_o.irq_request = status_d[ADF_POS] & status_d[ADIE_POS];
    res_o.converting  = active_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_RES; i++) begin
        result_q[i] <= '0;
      end
      status_q <= '0;
      trge_q   <= 1'b0;
      latch_q  <= '0;
      chan_q   <= '0;
      cnt_q    <= '0;
      active_q <= 1'b0;
    end else if (fire_i) begin
      result_q <= result_d;
      status_q <= status_d;
      trge_q   <= trge_d;
      latch_q  <= latch_d;
      chan_q   <= chan_d;
      cnt_q    <= cnt_d;
      active_q <= active_d;
    end
  end

endmodule

>>> rtl/core/adc_single_scan_controller.sv
// ----------------------------------------------------------------------------
// adc_single_scan_controller
// Register-mapped controller of a 10-bit A/D converter, single and scan mode.
// ----------------------------------------------------------------------------
// Each request (bus read, bus write, one-state tick, external trigger or DTC
// flag clear) gives exactly one result with the read byte, the ADI request
// and the converting flag. A request is captured in an input register and is
// applied to the register file once the output register is free; its result
// is then loaded into that output register and offered. One request
// is accepted in every cycle while the output side keeps taking results; a
// stalled result holds the request behind it, which then stalls the input.
// Conversion timing counts tick requests, not clock cycles.
module adc_single_scan_controller
  import adc_ssc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          req_type_i,
  input  logic [3:0]          offset_i,
  input  logic [7:0]          wdata_i,
  input  logic [SAMPLE_W-1:0] sample_zero_i,
  input  logic [SAMPLE_W-1:0] sample_one_i,
  input  logic [SAMPLE_W-1:0] sample_two_i,
  input  logic [SAMPLE_W-1:0] sample_three_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          rdata_o,
  output logic                irq_request_o,
  output logic                converting_o
);

  item_t item_q;
  logic  item_valid_q;
  res_t  res_d, res_q;
  logic  res_valid_q;
  logic  out_free;
  logic  fire;
  logic  in_xfer;

  // handshake: the core runs when the output register can take a result
  assign out_free   = !res_valid_q || !out_stall_i;
  assign fire       = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.req_type     <= req_type_i;
      item_q.offset       <= offset_i;
      item_q.wdata        <= wdata_i;
      item_q.sample_zero  <= sample_zero_i;
      item_q.sample_one   <= sample_one_i;
      item_q.sample_two   <= sample_two_i;
      item_q.sample_three <= sample_three_i;
    end
  end

  // register file and conversion sequencer
  adc_ssc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (res_d)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign rdata_o       = res_q.rdata;
  assign irq_request_o = res_q.irq_request;
  assign converting_o  = res_q.converting;

endmodule
